### hw/rtl/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// Widths, reset values, command constants and shared types of the balance
// controller core.
// ----------------------------------------------------------------------------
package bcc_pkg;

	localparam int ANGLE_W   = 9;
	localparam int RATE_W    = 16;
	localparam int GAIN_W    = 24;
	localparam int OFFS_W    = 9;
	localparam int LIMIT_W   = 15;
	localparam int DRIVE_W   = 17;
	localparam int OUT_W     = 18;
	localparam int SUM_W     = 16;
	localparam int TANG_W    = 4;
	localparam int TSPD_W    = 6;
	localparam int AERR_W    = 11;
	localparam int SERR_W    = 17;
	localparam int ACC_W     = 18;
	localparam int TURN_W    = 17;
	localparam int TURN3_W   = 18;
	localparam int PROD_W    = 41;
	localparam int TERM_W    = 34;
	localparam int DSUM_W    = 35;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 3;
	localparam int FRAC_W    = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ANGLE_GAIN     = 3'd0,
		CFG_RATE_GAIN      = 3'd1,
		CFG_SPEED_GAIN     = 3'd2,
		CFG_INTEGRAL_GAIN  = 3'd3,
		CFG_BALANCE_OFFSET = 3'd4,
		CFG_INTEGRAL_LIMIT = 3'd5,
		CFG_DRIVE_MAX      = 3'd6,
		CFG_DRIVE_MIN      = 3'd7
	} cfg_idx_t;

	localparam logic signed [GAIN_W-1:0]  ANGLE_GAIN_RST     = -24'sd1280000;
	localparam logic signed [GAIN_W-1:0]  RATE_GAIN_RST      = 24'sd2865;
	localparam logic signed [GAIN_W-1:0]  SPEED_GAIN_RST     = 24'sd768000;
	localparam logic signed [GAIN_W-1:0]  INTEGRAL_GAIN_RST  = 24'sd6912;
	localparam logic signed [OFFS_W-1:0]  BALANCE_OFFSET_RST = 9'sd0;
	localparam logic [LIMIT_W-1:0]        INTEGRAL_LIMIT_RST = 15'd6000;
	localparam logic signed [DRIVE_W-1:0] DRIVE_MAX_RST      = 17'sd65535;
	localparam logic signed [DRIVE_W-1:0] DRIVE_MIN_RST      = -17'sd65535;

	localparam logic signed [TURN_W-1:0] TURN_FIXED = 17'sd15000;
	localparam logic signed [TANG_W-1:0] FWD_ANGLE  = 4'sd7;
	localparam logic signed [TSPD_W-1:0] FWD_SPEED  = 6'sd15;
	localparam logic signed [TANG_W-1:0] REV_ANGLE  = -4'sd7;
	localparam logic signed [TSPD_W-1:0] REV_SPEED  = -6'sd15;

	typedef struct packed {
		logic en_s2;
		logic en_s3;
	} bcc_adv_t;

endpackage

### hw/rtl/bcc_gain_path.sv
// ----------------------------------------------------------------------------
// bcc_gain_path
// Gain multiplies (stage 2) and the Q.8 scaling of the PD and PI terms with
// truncation toward zero (stage 3).
// ----------------------------------------------------------------------------
module bcc_gain_path
	import bcc_pkg::*;
(
	input  logic                     clk,
	input  bcc_adv_t                 adv,
	input  logic signed [GAIN_W-1:0] angle_gain,
	input  logic signed [GAIN_W-1:0] rate_gain,
	input  logic signed [GAIN_W-1:0] speed_gain,
	input  logic signed [GAIN_W-1:0] integral_gain,
	input  logic signed [AERR_W-1:0] ang_err_s1,
	input  logic signed [RATE_W-1:0] prate_s1,
	input  logic signed [SERR_W-1:0] serr_s1,
	input  logic signed [SUM_W-1:0]  sum_s1,
	output logic signed [TERM_W-1:0] pd_s3,
	output logic signed [TERM_W-1:0] pi_s3
);

	logic signed [GAIN_W+AERR_W-1:0] m_ang;
	logic signed [GAIN_W+RATE_W-1:0] m_rate;
	logic signed [GAIN_W+SERR_W-1:0] m_spd;
	logic signed [GAIN_W+SUM_W-1:0]  m_int;

	logic signed [PROD_W-1:0] p_ang_s2;
	logic signed [PROD_W-1:0] p_rate_s2;
	logic signed [PROD_W-1:0] p_spd_s2;
	logic signed [PROD_W-1:0] p_int_s2;

	logic signed [PROD_W-1:0] pd_raw;
	logic signed [PROD_W-1:0] pi_raw;
	logic signed [PROD_W-1:0] pd_bias;
	logic signed [PROD_W-1:0] pi_bias;
	logic signed [PROD_W-1:0] pd_div;
	logic signed [PROD_W-1:0] pi_div;

	assign m_ang  = angle_gain * ang_err_s1;
	assign m_rate = rate_gain * prate_s1;
	assign m_spd  = speed_gain * serr_s1;
	assign m_int  = integral_gain * sum_s1;

	always_ff @(posedge clk) begin
		if (adv.en_s2) begin
			p_ang_s2  <= PROD_W'(m_ang);
			p_rate_s2 <= PROD_W'(m_rate);
			p_spd_s2  <= PROD_W'(m_spd);
			p_int_s2  <= PROD_W'(m_int);
		end
	end

	// round toward zero: bias negative values before the arithmetic shift
	always_comb begin
		pd_raw  = p_ang_s2 + p_rate_s2;
		pi_raw  = p_spd_s2 + p_int_s2;
		pd_bias = pd_raw[PROD_W-1] ? pd_raw + PROD_W'((1 << FRAC_W) - 1) : pd_raw;
		pi_bias = pi_raw[PROD_W-1] ? pi_raw + PROD_W'((1 << FRAC_W) - 1) : pi_raw;
		pd_div  = pd_bias >>> FRAC_W;
		pi_div  = pi_bias >>> FRAC_W;
	end

	always_ff @(posedge clk) begin
		if (adv.en_s3) begin
			pd_s3 <= TERM_W'(pd_div);
			pi_s3 <= TERM_W'(pi_div);
		end
	end

endmodule

### hw/rtl/balance_robot_cascade_controller_core.sv
// ----------------------------------------------------------------------------
// balance_robot_cascade_controller_core
// Cascade PD/PI balance controller with turn drive for a two-wheel robot.
// ----------------------------------------------------------------------------
// One sensor word in, one pair of wheel drive values out. The core is a
// four-stage pipeline: error terms and the speed integrator at the input
// register, the four gain multiplies, the Q.8 scaling, then drive saturation
// and turn mixing into the output register. A new word is taken every cycle
// unless in_stall is high; the loops from one word to the next are the first
// stage integrator add and clamp and its command targets. in_stall rises only
// when all four stages hold words and the output is stalled. Registers are to
// be written through the cfg port while the core is idle, which the core does
// not enforce; commands in a word change the targets seen by the following word.
module balance_robot_cascade_controller_core
	import bcc_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [ANGLE_W-1:0]   pitch_angle,
	input  logic signed [RATE_W-1:0]    pitch_rate,
	input  logic signed [RATE_W-1:0]    yaw_rate,
	input  logic signed [RATE_W-1:0]    wheel_speed,
	input  logic                        cmd_forward,
	input  logic                        cmd_halt,
	input  logic                        cmd_reverse,
	input  logic                        cmd_left,
	input  logic                        cmd_right,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [OUT_W-1:0]     left_drive,
	output logic signed [OUT_W-1:0]     right_drive,
	input  logic                        cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_W-1:0]            cfg_data
);

	logic signed [GAIN_W-1:0]  angle_gain_q;
	logic signed [GAIN_W-1:0]  rate_gain_q;
	logic signed [GAIN_W-1:0]  speed_gain_q;
	logic signed [GAIN_W-1:0]  integral_gain_q;
	logic signed [OFFS_W-1:0]  balance_offset_q;
	logic [LIMIT_W-1:0]        integral_limit_q;
	logic signed [DRIVE_W-1:0] drive_max_q;
	logic signed [DRIVE_W-1:0] drive_min_q;

	logic signed [SUM_W-1:0]  sum_q;
	logic signed [TANG_W-1:0] target_angle_q;
	logic signed [TSPD_W-1:0] target_speed_q;

	logic v_s1, v_s2, v_s3;
	logic out_free, s3_free, s2_free, s1_free, accept;
	bcc_adv_t adv;

	logic signed [AERR_W-1:0]  ang_err;
	logic signed [SERR_W-1:0]  serr;
	logic signed [ACC_W-1:0]   acc_raw;
	logic signed [ACC_W-1:0]   lim_pos;
	logic signed [ACC_W-1:0]   lim_neg;
	logic signed [ACC_W-1:0]   acc_hi;
	logic signed [ACC_W-1:0]   acc_clamped;
	logic signed [TURN3_W-1:0] yaw3;
	logic signed [TURN3_W-1:0] yaw3_neg;
	logic signed [TURN3_W-1:0] yaw3_bias;
	logic signed [TURN3_W-1:0] yaw_half;
	logic signed [TURN_W-1:0]  turn;

	logic signed [AERR_W-1:0] ang_err_s1;
	logic signed [RATE_W-1:0] prate_s1;
	logic signed [SERR_W-1:0] serr_s1;
	logic signed [SUM_W-1:0]  sum_s1;
	logic signed [TURN_W-1:0] turn_s1, turn_s2, turn_s3;
	logic signed [TERM_W-1:0] pd_s3, pi_s3;

	logic signed [DSUM_W-1:0]  drive_sum;
	logic signed [DSUM_W-1:0]  drive_hi;
	logic signed [DSUM_W-1:0]  drive_lo;
	logic signed [DRIVE_W-1:0] drive;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_gain_q     <= ANGLE_GAIN_RST;
			rate_gain_q      <= RATE_GAIN_RST;
			speed_gain_q     <= SPEED_GAIN_RST;
			integral_gain_q  <= INTEGRAL_GAIN_RST;
			balance_offset_q <= BALANCE_OFFSET_RST;
			integral_limit_q <= INTEGRAL_LIMIT_RST;
			drive_max_q      <= DRIVE_MAX_RST;
			drive_min_q      <= DRIVE_MIN_RST;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ANGLE_GAIN:     angle_gain_q     <= GAIN_W'(cfg_data);
				CFG_RATE_GAIN:      rate_gain_q      <= GAIN_W'(cfg_data);
				CFG_SPEED_GAIN:     speed_gain_q     <= GAIN_W'(cfg_data);
				CFG_INTEGRAL_GAIN:  integral_gain_q  <= GAIN_W'(cfg_data);
				CFG_BALANCE_OFFSET: balance_offset_q <= cfg_data[OFFS_W-1:0];
				CFG_INTEGRAL_LIMIT: integral_limit_q <= cfg_data[LIMIT_W-1:0];
				CFG_DRIVE_MAX:      drive_max_q      <= cfg_data[DRIVE_W-1:0];
				CFG_DRIVE_MIN:      drive_min_q      <= cfg_data[DRIVE_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline flow
	assign out_free  = !out_valid || !out_stall;
	assign s3_free   = !v_s3 || out_free;
	assign s2_free   = !v_s2 || s3_free;
	assign s1_free   = !v_s1 || s2_free;
	assign in_stall  = !s1_free;
	assign accept    = in_valid && s1_free;
	assign adv.en_s2 = s2_free;
	assign adv.en_s3 = s3_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (s1_free)  v_s1 <= accept;
			if (s2_free)  v_s2 <= v_s1;
			if (s3_free)  v_s3 <= v_s2;
			if (out_free) out_valid <= v_s3;
		end
	end

	// error terms, integrator and turn
	always_comb begin
		ang_err  = AERR_W'(balance_offset_q) + AERR_W'(target_angle_q)
			- AERR_W'(pitch_angle);
		serr     = SERR_W'(target_speed_q) - SERR_W'(wheel_speed);
		acc_raw  = ACC_W'(sum_q) + ACC_W'(serr);
		lim_pos  = ACC_W'(integral_limit_q);
		lim_neg  = -lim_pos;
		acc_hi   = (acc_raw > lim_pos) ? lim_pos : acc_raw;
		acc_clamped = (acc_hi < lim_neg) ? lim_neg : acc_hi;

		yaw3      = TURN3_W'(yaw_rate) + (TURN3_W'(yaw_rate) <<< 1);
		yaw3_neg  = -yaw3;
		yaw3_bias = yaw3_neg[TURN3_W-1] ? yaw3_neg + TURN3_W'(1) : yaw3_neg;
		yaw_half  = yaw3_bias >>> 1;
		if (cmd_left) begin
			turn = TURN_FIXED;
		end else if (cmd_right) begin
			turn = -TURN_FIXED;
		end else begin
			turn = TURN_W'(yaw_half);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q          <= '0;
			target_angle_q <= '0;
			target_speed_q <= '0;
		end else if (accept) begin
			sum_q <= SUM_W'(acc_clamped);
			if (cmd_reverse) begin
				target_angle_q <= REV_ANGLE;
				target_speed_q <= REV_SPEED;
			end else if (cmd_halt) begin
				target_angle_q <= '0;
				target_speed_q <= '0;
			end else if (cmd_forward) begin
				target_angle_q <= FWD_ANGLE;
				target_speed_q <= FWD_SPEED;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free) begin
			ang_err_s1 <= ang_err;
			prate_s1   <= pitch_rate;
			serr_s1    <= serr;
			sum_s1     <= SUM_W'(acc_clamped);
			turn_s1    <= turn;
		end
		if (s2_free) turn_s2 <= turn_s1;
		if (s3_free) turn_s3 <= turn_s2;
	end

	bcc_gain_path u_gain (
		.clk           (clk),
		.adv           (adv),
		.angle_gain    (angle_gain_q),
		.rate_gain     (rate_gain_q),
		.speed_gain    (speed_gain_q),
		.integral_gain (integral_gain_q),
		.ang_err_s1    (ang_err_s1),
		.prate_s1      (prate_s1),
		.serr_s1       (serr_s1),
		.sum_s1        (sum_s1),
		.pd_s3         (pd_s3),
		.pi_s3         (pi_s3)
	);

	// saturation, upper bound first
	always_comb begin
		drive_sum = DSUM_W'(pd_s3) + DSUM_W'(pi_s3);
		drive_hi  = (drive_sum > DSUM_W'(drive_max_q)) ? DSUM_W'(drive_max_q) : drive_sum;
		drive_lo  = (drive_hi < DSUM_W'(drive_min_q)) ? DSUM_W'(drive_min_q) : drive_hi;
		drive     = DRIVE_W'(drive_lo);
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			left_drive  <= OUT_W'(drive) + OUT_W'(turn_s3);
			right_drive <= OUT_W'(drive) - OUT_W'(turn_s3);
		end
	end

endmodule

### hw/rtl/bcc_checker.sv
// ----------------------------------------------------------------------------
// bcc_checker
// Port-level checks of the balance controller core, bound to the top level.
// ----------------------------------------------------------------------------
module bcc_checker
	import bcc_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic signed [OUT_W-1:0]   left_drive,
	input logic signed [OUT_W-1:0]   right_drive
);

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(left_drive) && $stable(right_drive))
		else $error("output word changed while stalled");

	// input only backs up when the whole pipe is full behind a stalled output
	a_stall_cause: assert property (@(posedge clk)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// wheels differ by twice the turn term
	a_turn_parity: assert property (@(posedge clk)
		out_valid |-> left_drive[0] == right_drive[0])
		else $error("left and right drive differ by an odd amount");

	// reset empties the output
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid && !in_stall)
		else $error("output valid during reset");

endmodule

bind balance_robot_cascade_controller_core bcc_checker u_bcc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.left_drive  (left_drive),
	.right_drive (right_drive)
);

### test/balance_robot_cascade_controller_core_test.sv
// ----------------------------------------------------------------------------
// balance_robot_cascade_controller_core_test
// Self-checking bench for the cascade balance controller core. Sensor words
// go in through the valid/stall port with random gaps. A ledger class keeps
// its own copy of the gains, limits, targets and speed integrator, predicts
// the wheel drive pair of every word taken, and checks each result in order.
// The run covers the reset gains, extreme and crossed settings, and random
// settings. It also holds the output off long enough to fill the pipeline.
// ----------------------------------------------------------------------------
module balance_robot_cascade_controller_core_test
	import bcc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIPE_LAT    = 4;
	localparam int WORDS_EACH  = 313;
	localparam int HOLD_CYCLES = 150;
	localparam int STALL_LIMIT = 1000;

	localparam logic [4:0] CMD_FWD   = 5'b00001;
	localparam logic [4:0] CMD_HALT  = 5'b00010;
	localparam logic [4:0] CMD_REV   = 5'b00100;
	localparam logic [4:0] CMD_LEFT  = 5'b01000;
	localparam logic [4:0] CMD_RIGHT = 5'b10000;

	typedef struct {
		logic signed [ANGLE_W-1:0] pitch;
		logic signed [RATE_W-1:0]  prate;
		logic signed [RATE_W-1:0]  yaw;
		logic signed [RATE_W-1:0]  wspeed;
		logic                      fwd;
		logic                      halt;
		logic                      rev;
		logic                      lft;
		logic                      rgt;
	} sample_t;

	typedef struct {
		logic [OUT_W-1:0] left_drv;
		logic [OUT_W-1:0] right_drv;
	} drive_pair_t;

	class drive_ledger;
		longint kp, kd, ks, ki, offs, ilim, dmax, dmin;
		longint err_sum, tang, tspd;
		drive_pair_t due[$];
		int errors;

		function new();
			kp = longint'(ANGLE_GAIN_RST);
			kd = longint'(RATE_GAIN_RST);
			ks = longint'(SPEED_GAIN_RST);
			ki = longint'(INTEGRAL_GAIN_RST);
			offs = longint'(BALANCE_OFFSET_RST);
			ilim = longint'(INTEGRAL_LIMIT_RST);
			dmax = longint'(DRIVE_MAX_RST);
			dmin = longint'(DRIVE_MIN_RST);
			err_sum = 0;
			tang = 0;
			tspd = 0;
			errors = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
			logic signed [GAIN_W-1:0]  g;
			logic signed [OFFS_W-1:0]  o;
			logic signed [DRIVE_W-1:0] d;
			g = data[GAIN_W-1:0];
			o = data[OFFS_W-1:0];
			d = data[DRIVE_W-1:0];
			case (idx)
				CFG_ANGLE_GAIN:     kp = longint'(g);
				CFG_RATE_GAIN:      kd = longint'(g);
				CFG_SPEED_GAIN:     ks = longint'(g);
				CFG_INTEGRAL_GAIN:  ki = longint'(g);
				CFG_BALANCE_OFFSET: offs = longint'(o);
				CFG_INTEGRAL_LIMIT: ilim = longint'(data[LIMIT_W-1:0]);
				CFG_DRIVE_MAX:      dmax = longint'(d);
				CFG_DRIVE_MIN:      dmin = longint'(d);
				default: ;
			endcase
		endfunction

		function void note_word(sample_t w);
			longint aerr, pd, serr, pi, drv, turn;
			drive_pair_t p;
			aerr = offs + tang - longint'(w.pitch);
			pd = (kp * aerr + kd * longint'(w.prate)) / 256;
			serr = tspd - longint'(w.wspeed);
			err_sum = err_sum + serr;
			if (err_sum > ilim)
				err_sum = ilim;
			if (err_sum < -ilim)
				err_sum = -ilim;
			pi = (ks * serr + ki * err_sum) / 256;
			drv = pd + pi;
			if (drv > dmax)
				drv = dmax;
			if (drv < dmin)
				drv = dmin;
			if (w.fwd) begin
				tang = longint'(FWD_ANGLE);
				tspd = longint'(FWD_SPEED);
			end
			if (w.halt) begin
				tang = 0;
				tspd = 0;
			end
			if (w.rev) begin
				tang = longint'(REV_ANGLE);
				tspd = longint'(REV_SPEED);
			end
			if (w.lft)
				turn = longint'(TURN_FIXED);
			else if (w.rgt)
				turn = -longint'(TURN_FIXED);
			else
				turn = (-3 * longint'(w.yaw)) / 2;
			p.left_drv = OUT_W'(drv + turn);
			p.right_drv = OUT_W'(drv - turn);
			due.push_back(p);
		endfunction

		function void check_word(logic [OUT_W-1:0] l, logic [OUT_W-1:0] r);
			drive_pair_t p;
			if (due.size() == 0) begin
				$error("left_drive: nothing expected, got %0d", $signed(l));
				errors++;
				return;
			end
			p = due.pop_front();
			if (l !== p.left_drv) begin
				$error("left_drive: expected %0d, got %0d", $signed(p.left_drv), $signed(l));
				errors++;
			end
			if (r !== p.right_drv) begin
				$error("right_drive: expected %0d, got %0d", $signed(p.right_drv), $signed(r));
				errors++;
			end
		endfunction

		function int owed();
			return due.size();
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic signed [ANGLE_W-1:0] pitch_angle;
	logic signed [RATE_W-1:0]  pitch_rate;
	logic signed [RATE_W-1:0]  yaw_rate;
	logic signed [RATE_W-1:0]  wheel_speed;
	logic                      cmd_forward;
	logic                      cmd_halt;
	logic                      cmd_reverse;
	logic                      cmd_left;
	logic                      cmd_right;
	logic                      out_valid;
	logic                      out_stall;
	logic signed [OUT_W-1:0]   left_drive;
	logic signed [OUT_W-1:0]   right_drive;
	logic                      cfg_wr_en;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CFG_W-1:0]          cfg_data;

	bit calm;
	bit hold_off;
	drive_ledger ledger = new();

	balance_robot_cascade_controller_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pitch_angle(pitch_angle),
		.pitch_rate(pitch_rate),
		.yaw_rate(yaw_rate),
		.wheel_speed(wheel_speed),
		.cmd_forward(cmd_forward),
		.cmd_halt(cmd_halt),
		.cmd_reverse(cmd_reverse),
		.cmd_left(cmd_left),
		.cmd_right(cmd_right),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.left_drive(left_drive),
		.right_drive(right_drive),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic int idle_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic sample_t make_word(int p, int pr, int y, int ws, logic [4:0] cmds);
		sample_t w;
		w.pitch = ANGLE_W'(p);
		w.prate = RATE_W'(pr);
		w.yaw = RATE_W'(y);
		w.wspeed = RATE_W'(ws);
		w.fwd = |(cmds & CMD_FWD);
		w.halt = |(cmds & CMD_HALT);
		w.rev = |(cmds & CMD_REV);
		w.lft = |(cmds & CMD_LEFT);
		w.rgt = |(cmds & CMD_RIGHT);
		return w;
	endfunction

	function automatic sample_t random_word();
		sample_t w;
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			w.pitch = ANGLE_W'(int'($urandom_range(0, 60)) - 30);
		else if (r < 90)
			w.pitch = ANGLE_W'(int'($urandom_range(0, 360)) - 180);
		else
			w.pitch = ANGLE_W'($urandom);
		w.prate = ($urandom_range(0, 9) < 6) ?
			RATE_W'(int'($urandom_range(0, 4000)) - 2000) : RATE_W'($urandom);
		w.yaw = ($urandom_range(0, 9) < 6) ?
			RATE_W'(int'($urandom_range(0, 4000)) - 2000) : RATE_W'($urandom);
		w.wspeed = ($urandom_range(0, 9) < 8) ?
			RATE_W'(int'($urandom_range(0, 300)) - 150) : RATE_W'($urandom);
		w.fwd = ($urandom_range(0, 7) == 0);
		w.halt = ($urandom_range(0, 7) == 0);
		w.rev = ($urandom_range(0, 7) == 0);
		w.lft = ($urandom_range(0, 4) == 0);
		w.rgt = ($urandom_range(0, 4) == 0);
		return w;
	endfunction

	task automatic send_word(sample_t w);
		int gap;
		@(negedge clk);
		pitch_angle = w.pitch;
		pitch_rate = w.prate;
		yaw_rate = w.yaw;
		wheel_speed = w.wspeed;
		cmd_forward = w.fwd;
		cmd_halt = w.halt;
		cmd_reverse = w.rev;
		cmd_left = w.lft;
		cmd_right = w.rgt;
		in_valid = 1;
		do @(posedge clk); while (in_stall);
		gap = idle_len();
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid = 0;
		while (ledger.owed() > 0)
			@(posedge clk);
		repeat (PIPE_LAT + 2) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, longint v);
		logic [CFG_W-1:0] keep;
		logic [CFG_W-1:0] data;
		int w;
		case (idx)
			CFG_BALANCE_OFFSET:           w = OFFS_W;
			CFG_INTEGRAL_LIMIT:           w = LIMIT_W;
			CFG_DRIVE_MAX, CFG_DRIVE_MIN: w = DRIVE_W;
			default:                      w = GAIN_W;
		endcase
		keep = '1;
		keep = keep >> (CFG_W - w);
		// bits above the register width are junk and must be ignored
		data = (CFG_W'($urandom) & ~keep) | (v[CFG_W-1:0] & keep);
		@(negedge clk);
		cfg_wr_en = 1;
		cfg_index = idx;
		cfg_data = data;
		ledger.set_reg(idx, data);
	endtask

	task automatic apply_setting(longint ka, longint kr, longint ksp, longint kin,
			longint offs, longint lim, longint dmax, longint dmin);
		write_reg(CFG_ANGLE_GAIN, ka);
		write_reg(CFG_RATE_GAIN, kr);
		write_reg(CFG_SPEED_GAIN, ksp);
		write_reg(CFG_INTEGRAL_GAIN, kin);
		write_reg(CFG_BALANCE_OFFSET, offs);
		write_reg(CFG_INTEGRAL_LIMIT, lim);
		write_reg(CFG_DRIVE_MAX, dmax);
		write_reg(CFG_DRIVE_MIN, dmin);
		@(negedge clk);
		cfg_wr_en = 0;
	endtask

	task automatic random_words(bit pressure);
		for (int i = 0; i < WORDS_EACH; i++) begin
			if (pressure && i == 100)
				hold_off = 1;
			if (pressure && i == 220)
				settle();
			send_word(random_word());
		end
		settle();
	endtask

	// receiver side: random stall runs, plus one long hold on request
	initial begin : receiver
		int run;
		out_stall = 0;
		run = 0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				hold_off = 0;
				out_stall = 1;
				run = HOLD_CYCLES;
			end else if (run > 0) begin
				run--;
			end else if (calm) begin
				out_stall = 0;
			end else begin
				out_stall = ($urandom_range(0, 2) == 0);
				run = idle_len();
			end
		end
	end

	always @(posedge clk) begin : monitor
		sample_t w;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				w.pitch = pitch_angle;
				w.prate = pitch_rate;
				w.yaw = yaw_rate;
				w.wspeed = wheel_speed;
				w.fwd = cmd_forward;
				w.halt = cmd_halt;
				w.rev = cmd_reverse;
				w.lft = cmd_left;
				w.rgt = cmd_right;
				ledger.note_word(w);
			end
			if (out_valid && !out_stall)
				ledger.check_word(left_drive, right_drive);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		arst_n = 0;
		in_valid = 0;
		pitch_angle = 0;
		pitch_rate = 0;
		yaw_rate = 0;
		wheel_speed = 0;
		cmd_forward = 0;
		cmd_halt = 0;
		cmd_reverse = 0;
		cmd_left = 0;
		cmd_right = 0;
		cfg_wr_en = 0;
		cfg_index = CFG_ANGLE_GAIN;
		cfg_data = 0;
		calm = 0;
		hold_off = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed words at reset gains
		send_word(make_word(0, 0, 0, 0, 0));
		send_word(make_word(180, 0, 0, 0, 0));
		send_word(make_word(-180, 0, 0, 0, 0));
		send_word(make_word(255, 0, 0, 0, 0));
		send_word(make_word(-256, 0, 0, 0, 0));
		send_word(make_word(0, 32767, 0, 0, 0));
		send_word(make_word(0, -32768, 0, 0, 0));
		send_word(make_word(0, 0, 32767, 0, 0));
		send_word(make_word(0, 0, -32768, 0, 0));
		send_word(make_word(0, 0, -3, 0, 0));
		send_word(make_word(0, 0, 3, 0, 0));
		send_word(make_word(0, 0, 0, 32767, 0));
		send_word(make_word(0, 0, 0, 32767, 0));
		send_word(make_word(0, 0, 0, -32768, 0));
		send_word(make_word(0, 0, 0, -32768, 0));
		send_word(make_word(5, 100, 200, 10, CMD_LEFT));
		send_word(make_word(5, 100, 200, 10, CMD_RIGHT));
		send_word(make_word(5, 100, 200, 10, CMD_LEFT | CMD_RIGHT));
		send_word(make_word(0, 0, 0, 0, CMD_FWD));
		send_word(make_word(3, -50, 7, 20, 0));
		send_word(make_word(0, 0, 0, 0, CMD_FWD | CMD_HALT));
		send_word(make_word(0, 0, 0, 0, CMD_REV));
		send_word(make_word(-3, 50, -7, -20, CMD_FWD | CMD_HALT | CMD_REV));
		send_word(make_word(1, 1, 1, 1, CMD_HALT | CMD_REV));
		send_word(make_word(1, 1, 1, 1, CMD_HALT));
		random_words(1);

		// upper extremes
		apply_setting(8388607, 8388607, 8388607, 8388607, 255, 32767, 65535, -65536);
		random_words(0);

		// lower extremes, zero integral limit, crossed drive bounds
		apply_setting(-8388608, -8388608, -8388608, -8388608, -256, 0, -65536, 65535);
		random_words(0);

		// back-to-back traffic with an asymmetric drive window
		calm = 1;
		apply_setting(ANGLE_GAIN_RST, RATE_GAIN_RST, SPEED_GAIN_RST, INTEGRAL_GAIN_RST,
			-12, 100, 20000, -5000);
		random_words(0);
		calm = 0;

		// anything the registers can hold
		apply_setting($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom);
		random_words(0);

		apply_setting(int'($urandom_range(0, 2560000)) - 1280000,
			int'($urandom_range(0, 20000)) - 10000,
			int'($urandom_range(0, 1600000)) - 800000,
			int'($urandom_range(0, 20000)) - 10000,
			int'($urandom_range(0, 360)) - 180, $urandom_range(0, 32767),
			$urandom_range(0, 65535), -int'($urandom_range(0, 65535)));
		random_words(0);

		if (ledger.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
